@@ rtl/nsc_pkg.sv @@
// ----------------------------------------------------------------------------
// nsc_pkg
// Shared types, character codes and decode functions of the sentence checker.
// ----------------------------------------------------------------------------
package nsc_pkg;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;

    localparam logic [7:0] DIGIT_OFS = 8'd48;
    localparam logic [7:0] LOWER_OFS = 8'd87;
    localparam logic [7:0] UPPER_OFS = 8'd55;

    localparam logic [23:0] TYPE_GLL = 24'h474C4C;
    localparam logic [23:0] TYPE_GSA = 24'h475341;
    localparam logic [23:0] TYPE_ZDA = 24'h5A4441;

    localparam logic [2:0] POS_TYPE_FIRST  = 3'd2;
    localparam logic [2:0] POS_TYPE_SECOND = 3'd3;
    localparam logic [2:0] POS_TYPE_THIRD  = 3'd4;
    localparam logic [2:0] POS_MAX         = 3'd7;

    typedef enum logic [1:0] {
        KIND_UNKNOWN = 2'd0,
        KIND_GLL     = 2'd1,
        KIND_GSA     = 2'd2,
        KIND_ZDA     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        VERDICT_OK           = 2'd0,
        VERDICT_UNKNOWN_TYPE = 2'd1,
        VERDICT_MISMATCH     = 2'd2,
        VERDICT_BAD_HEX      = 2'd3
    } verdict_t;

    typedef struct packed {
        kind_t      sentence_kind;
        verdict_t   verdict;
        logic [7:0] computed_sum;
        logic [7:0] received_sum;
    } result_t;

    typedef struct packed {
        logic       bad;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t       h;
        logic [7:0] diff;
        h    = '0;
        diff = '0;
        if (c >= "0" && c <= "9") begin
            diff = c - DIGIT_OFS;
        end
        else if (c >= "a" && c <= "f") begin
            diff = c - LOWER_OFS;
        end
        else if (c >= "A" && c <= "F") begin
            diff = c - UPPER_OFS;
        end
        else begin
            h.bad = 1'b1;
        end
        h.value = diff[3:0];
        return h;
    endfunction

    function automatic kind_t kind_decode(input logic [23:0] letters);
        kind_t k;
        priority if (letters == TYPE_GLL) begin
            k = KIND_GLL;
        end
        else if (letters == TYPE_GSA) begin
            k = KIND_GSA;
        end
        else if (letters == TYPE_ZDA) begin
            k = KIND_ZDA;
        end
        else begin
            k = KIND_UNKNOWN;
        end
        return k;
    endfunction

endpackage

@@ rtl/nsc_byte_if.sv @@
// ----------------------------------------------------------------------------
// nsc_byte_if
// Valid/ready channel carrying one received character per transaction.
// ----------------------------------------------------------------------------
interface nsc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/nsc_result_if.sv @@
// ----------------------------------------------------------------------------
// nsc_result_if
// Valid/ready channel carrying one sentence result per transaction.
// ----------------------------------------------------------------------------
interface nsc_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] sentence_kind;
    logic [1:0] verdict;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;

    modport source (output valid, output sentence_kind, output verdict,
                    output computed_sum, output received_sum, input ready);
    modport sink   (input valid, input sentence_kind, input verdict,
                    input computed_sum, input received_sum, output ready);
endinterface

@@ rtl/nsc_in_stage.sv @@
// ----------------------------------------------------------------------------
// nsc_in_stage
// Input register for received characters, refilled in the cycle it drains.
// ----------------------------------------------------------------------------
module nsc_in_stage
    import nsc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    nsc_byte_if.sink         rx,
    input  logic             take,
    output logic             valid,
    output logic [7:0]       data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign rx.ready   = !valid_reg || take;
    assign valid_next = (rx.valid && rx.ready) || (valid_reg && !take);
    assign valid      = valid_reg;
    assign data       = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            byte_reg <= rx.rx_byte;
        end
    end

    // held character stays put until the parser takes it
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !take |=> valid_reg && $stable(byte_reg))
        else $error("input register lost a held character");

endmodule

@@ rtl/nsc_parser.sv @@
// ----------------------------------------------------------------------------
// nsc_parser
// Sentence phase machine: running xor, type capture and checksum decode.
// ----------------------------------------------------------------------------
module nsc_parser
    import nsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic [7:0] byte_data,
    input  logic       out_space,
    output logic       take,
    output logic       emit,
    output result_t    result
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_BODY = 2'd1,
        PH_HI   = 2'd2,
        PH_LO   = 2'd3
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [2:0]  pos_reg;
    logic [2:0]  pos_next;
    logic [23:0] type_reg;
    logic [23:0] type_next;
    logic [7:0]  xor_reg;
    logic [7:0]  xor_next;
    logic [3:0]  hi_nibble_reg;
    logic [3:0]  hi_nibble_next;
    logic        hi_bad_reg;
    logic        hi_bad_next;

    hex_t        digit;
    logic        is_dollar;
    logic [7:0]  recv_sum;
    kind_t       kind;
    verdict_t    verdict;

    assign is_dollar = (byte_data == CHAR_DOLLAR);
    assign digit     = hex_decode(byte_data);
    assign recv_sum  = {hi_nibble_reg, digit.value};
    assign kind      = kind_decode(type_reg);

    always_comb
    begin
        priority if (kind == KIND_UNKNOWN)
        begin
            verdict = VERDICT_UNKNOWN_TYPE;
        end
        else if (digit.bad || hi_bad_reg)
        begin
            verdict = VERDICT_BAD_HEX;
        end
        else if (recv_sum != xor_reg)
        begin
            verdict = VERDICT_MISMATCH;
        end
        else
        begin
            verdict = VERDICT_OK;
        end
    end

    assign emit = byte_valid && !is_dollar && (phase_reg == PH_LO);
    assign take = byte_valid && (!emit || out_space);

    assign result.sentence_kind = kind;
    assign result.verdict       = verdict;
    assign result.computed_sum  = xor_reg;
    assign result.received_sum  = recv_sum;

    always_comb
    begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        type_next      = type_reg;
        xor_next       = xor_reg;
        hi_nibble_next = hi_nibble_reg;
        hi_bad_next    = hi_bad_reg;
        if (is_dollar)
        begin
            phase_next     = PH_BODY;
            pos_next       = '0;
            type_next      = '0;
            xor_next       = '0;
            hi_nibble_next = '0;
            hi_bad_next    = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                PH_BODY:
                begin
                    if (byte_data == CHAR_STAR)
                    begin
                        phase_next = PH_HI;
                    end
                    else
                    begin
                        xor_next = xor_reg ^ byte_data;
                        unique case (pos_reg)
                            POS_TYPE_FIRST:  type_next[23:16] = byte_data;
                            POS_TYPE_SECOND: type_next[15:8]  = byte_data;
                            POS_TYPE_THIRD:  type_next[7:0]   = byte_data;
                            default:         type_next        = type_reg;
                        endcase
                        if (pos_reg != POS_MAX)
                        begin
                            pos_next = pos_reg + 3'd1;
                        end
                    end
                end
                PH_HI:
                begin
                    hi_nibble_next = digit.value;
                    hi_bad_next    = digit.bad;
                    phase_next     = PH_LO;
                end
                PH_LO:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            pos_reg       <= '0;
            type_reg      <= '0;
            xor_reg       <= '0;
            hi_nibble_reg <= '0;
            hi_bad_reg    <= 1'b0;
        end
        else if (take)
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            type_reg      <= type_next;
            xor_reg       <= xor_next;
            hi_nibble_reg <= hi_nibble_next;
            hi_bad_reg    <= hi_bad_next;
        end
    end

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        take && is_dollar |=> phase_reg == PH_BODY && xor_reg == '0 && type_reg == '0)
        else $error("dollar did not restart the sentence");

    a_ok_sums: assert property (@(posedge clk) disable iff (!rst_n)
        emit && verdict == VERDICT_OK |-> recv_sum == xor_reg && kind != KIND_UNKNOWN)
        else $error("accepted verdict with mismatching sums or unknown type");

endmodule

@@ rtl/nsc_out_stage.sv @@
// ----------------------------------------------------------------------------
// nsc_out_stage
// Result register driving the result channel.
// ----------------------------------------------------------------------------
module nsc_out_stage
    import nsc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  result_t       data,
    output logic          space,
    nsc_result_if.source  result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign space      = !valid_reg || result.ready;
    assign valid_next = load || (valid_reg && !result.ready);

    assign result.valid         = valid_reg;
    assign result.sentence_kind = result_reg.sentence_kind;
    assign result.verdict       = result_reg.verdict;
    assign result.computed_sum  = result_reg.computed_sum;
    assign result.received_sum  = result_reg.received_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= data;
        end
    end

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !valid_reg || result.ready)
        else $error("result register overwritten while full");

endmodule

@@ rtl/nmea_sentence_checker_top.sv @@
// ----------------------------------------------------------------------------
// nmea_sentence_checker_top
// NMEA 0183 sentence checksum checker: one result per completed sentence.
//
//   channel  | dir | payload                                        | per
//   rx       | in  | rx_byte[7:0]                                   | character
//   result   | out | sentence_kind[1:0] verdict[1:0]                | sentence
//            |     | computed_sum[7:0] received_sum[7:0]            |
//
// one character per cycle sustained while the result channel accepts; a
// character is registered in the input register before the phase machine
// folds it in; result appears the cycle after the low checksum digit is taken
// reset clears the phase machine and both valid flags; no clearing pass
// a stalled result channel holds back only the low checksum digit; other
// characters keep flowing while a result waits
// ----------------------------------------------------------------------------
module nmea_sentence_checker_top
    import nsc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    nsc_byte_if.sink      rx,
    nsc_result_if.source  result
);

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       take;
    logic       emit;
    logic       out_space;
    result_t    parsed;

    nsc_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .take  (take),
        .valid (byte_valid),
        .data  (byte_data)
    );

    nsc_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .out_space  (out_space),
        .take       (take),
        .emit       (emit),
        .result     (parsed)
    );

    nsc_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (emit && take),
        .data   (parsed),
        .space  (out_space),
        .result (result)
    );

endmodule

@@ sim/nmea_sentence_checker_top_tb.sv @@
// ----------------------------------------------------------------------------
// nmea_sentence_checker_top_tb
// Feeds directed and random NMEA character streams into the sentence checker,
// with random idle gaps on the character channel and random stalls on the
// result channel. A behavioral scanner predicts every sentence result, and
// each result transaction is compared with it field by field.
// ----------------------------------------------------------------------------
module nmea_sentence_checker_top_tb;
    import nsc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    typedef enum logic [1:0] {
        SCAN_IDLE = 2'd0,
        SCAN_BODY = 2'd1,
        SCAN_HIGH = 2'd2,
        SCAN_LOW  = 2'd3
    } scan_t;

    logic clk = 1'b0;
    logic rst_n;

    nsc_byte_if   rx_if ();
    nsc_result_if res_if ();

    nmea_sentence_checker_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_if),
        .result (res_if)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // scanner state mirrored from the block
    scan_t       scan        = SCAN_IDLE;
    logic [2:0]  body_count  = '0;
    logic [23:0] letters     = '0;
    logic [7:0]  running_sum = '0;
    logic [3:0]  high_val    = '0;
    logic        high_bad    = 1'b0;

    result_t     pending_results[$];
    result_t     due;
    int          chars_used   = 0;
    int          error_count  = 0;
    int          quiet_cycles = 0;
    bit          pace_traffic = 1'b1;

    function automatic hex_t hex_digit(input logic [7:0] c);
        hex_t       h;
        logic [7:0] d;
        h.bad = 1'b0;
        d     = '0;
        if (c >= "0" && c <= "9")
        begin
            d = c - DIGIT_OFS;
        end
        else if (c >= "a" && c <= "f")
        begin
            d = c - LOWER_OFS;
        end
        else if (c >= "A" && c <= "F")
        begin
            d = c - UPPER_OFS;
        end
        else
        begin
            h.bad = 1'b1;
        end
        h.value = d[3:0];
        return h;
    endfunction

    function automatic kind_t letters_to_kind(input logic [23:0] tag);
        case (tag)
            TYPE_GLL: return KIND_GLL;
            TYPE_GSA: return KIND_GSA;
            TYPE_ZDA: return KIND_ZDA;
            default:  return KIND_UNKNOWN;
        endcase
    endfunction

    // returns 1 when the character is not simply ignored
    function automatic bit scan_char(input logic [7:0] b);
        hex_t    h;
        result_t r;
        int      slot;
        if (b == CHAR_DOLLAR)
        begin
            scan        = SCAN_BODY;
            body_count  = '0;
            letters     = '0;
            running_sum = '0;
            high_val    = '0;
            high_bad    = 1'b0;
            return 1'b1;
        end
        case (scan)
            SCAN_IDLE:
            begin
                return 1'b0;
            end
            SCAN_BODY:
            begin
                if (b == CHAR_STAR)
                begin
                    scan = SCAN_HIGH;
                end
                else
                begin
                    running_sum = running_sum ^ b;
                    if (body_count >= POS_TYPE_FIRST && body_count <= POS_TYPE_THIRD)
                    begin
                        slot = int'(POS_TYPE_THIRD) - int'(body_count);
                        letters[8 * slot +: 8] = b;
                    end
                    if (body_count != POS_MAX)
                    begin
                        body_count = body_count + 3'd1;
                    end
                end
            end
            SCAN_HIGH:
            begin
                h        = hex_digit(b);
                high_val = h.value;
                high_bad = h.bad;
                scan     = SCAN_LOW;
            end
            SCAN_LOW:
            begin
                h                = hex_digit(b);
                r.sentence_kind  = letters_to_kind(letters);
                r.computed_sum   = running_sum;
                r.received_sum   = {high_val, h.value};
                if (r.sentence_kind == KIND_UNKNOWN)
                begin
                    r.verdict = VERDICT_UNKNOWN_TYPE;
                end
                else if (h.bad || high_bad)
                begin
                    r.verdict = VERDICT_BAD_HEX;
                end
                else if (r.received_sum != running_sum)
                begin
                    r.verdict = VERDICT_MISMATCH;
                end
                else
                begin
                    r.verdict = VERDICT_OK;
                end
                pending_results.push_back(r);
                scan = SCAN_IDLE;
            end
        endcase
        return 1'b1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10)
        begin
            return DIGIT_OFS + n;
        end
        return (upper ? UPPER_OFS : LOWER_OFS) + n;
    endfunction

    function automatic logic [7:0] random_body_byte(input bit printable);
        logic [7:0] b;
        do
        begin
            b = printable ? 8'($urandom_range(8'h20, 8'h7E)) : 8'($urandom_range(0, 255));
        end
        while (b == CHAR_DOLLAR || b == CHAR_STAR);
        return b;
    endfunction

    function automatic logic [7:0] bad_hex_byte();
        logic [7:0] b;
        hex_t       h;
        do
        begin
            b = 8'($urandom_range(0, 255));
            h = hex_digit(b);
        end
        while (!h.bad || b == CHAR_DOLLAR);
        return b;
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pace_traffic ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do
        begin
            @(posedge clk);
        end
        while (rx_if.ready !== 1'b1);
        if (scan_char(b))
        begin
            chars_used++;
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i]);
        end
    endtask

    task automatic send_summed(input logic [7:0] b, inout logic [7:0] sum);
        sum = sum ^ b;
        send_byte(b);
    endtask

    // full sentence, checksum xored with flip before it is sent
    task automatic send_sentence(input string body, input logic [7:0] flip, input bit upper);
        logic [7:0] sum;
        sum = '0;
        send_byte(CHAR_DOLLAR);
        for (int i = 0; i < body.len(); i++)
        begin
            send_summed(body[i], sum);
        end
        send_byte(CHAR_STAR);
        sum = sum ^ flip;
        send_byte(hex_char(sum[7:4], upper));
        send_byte(hex_char(sum[3:0], upper));
    endtask

    task automatic send_random_sentence();
        logic [7:0]  sum;
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [23:0] tag;
        int          slot;
        int          pick;
        sum = '0;
        send_byte(CHAR_DOLLAR);
        if ($urandom_range(0, 9) == 0)
        begin
            // short type field
            repeat ($urandom_range(0, 3))
            begin
                send_summed(random_body_byte(1'($urandom_range(0, 1))), sum);
            end
        end
        else
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                send_summed(random_body_byte(1'b0), sum);
                send_summed(random_body_byte(1'b1), sum);
            end
            else
            begin
                send_summed("G", sum);
                send_summed($urandom_range(0, 1) ? "P" : "N", sum);
            end
            case ($urandom_range(0, 5))
                0: tag = TYPE_GLL;
                1: tag = TYPE_GSA;
                2: tag = TYPE_ZDA;
                3:
                begin
                    tag  = $urandom_range(0, 1) ? TYPE_GSA : TYPE_ZDA;
                    slot = $urandom_range(0, 2);
                    tag[8 * slot +: 8] = random_body_byte(1'b1);
                end
                default: tag = {random_body_byte(1'b1), random_body_byte(1'b1),
                                random_body_byte(1'b0)};
            endcase
            send_summed(tag[23:16], sum);
            send_summed(tag[15:8], sum);
            send_summed(tag[7:0], sum);
            repeat ($urandom_range(0, 10))
            begin
                send_summed(random_body_byte($urandom_range(0, 3) != 0), sum);
            end
        end
        send_byte(CHAR_STAR);
        pick = $urandom_range(0, 9);
        if (pick == 8)
        begin
            sum = sum ^ 8'($urandom_range(1, 255));
        end
        hi = hex_char(sum[7:4], 1'($urandom_range(0, 1)));
        lo = hex_char(sum[3:0], 1'($urandom_range(0, 1)));
        if (pick == 9)
        begin
            case ($urandom_range(0, 2))
                0: hi = bad_hex_byte();
                1: lo = bad_hex_byte();
                default:
                begin
                    hi = bad_hex_byte();
                    lo = bad_hex_byte();
                end
            endcase
        end
        send_byte(hi);
        send_byte(lo);
    endtask

    task automatic send_broken_sentence();
        logic [3:0] n;
        send_byte(CHAR_DOLLAR);
        repeat ($urandom_range(0, 8)) send_byte(random_body_byte(1'($urandom_range(0, 1))));
        if ($urandom_range(0, 1))
        begin
            send_byte(CHAR_STAR);
            if ($urandom_range(0, 1))
            begin
                n = 4'($urandom_range(0, 15));
                send_byte(hex_char(n, 1'($urandom_range(0, 1))));
            end
        end
    endtask

    task automatic test_idle_bytes();
        send_byte(8'hFF);
        send_byte(CHAR_STAR);
        send_byte(8'h00);
    endtask

    task automatic test_known_kinds();
        // dollar in the middle of a sentence restarts it
        send_byte(CHAR_DOLLAR);
        send_text("GP");
        send_sentence("GPGLL", 8'h00, 1'b0);
        send_sentence("GPGSA", 8'hFF, 1'b1);
        // star as the high checksum digit
        send_byte(CHAR_DOLLAR);
        send_text("GNZDA");
        send_byte(CHAR_STAR);
        send_byte(CHAR_STAR);
        send_byte("0");
    endtask

    task automatic test_unknown_type();
        // short type field beats a bad hex digit
        send_byte(CHAR_DOLLAR);
        send_text("X");
        send_byte(CHAR_STAR);
        send_byte("g");
        send_byte("G");
    endtask

    task automatic test_random_traffic(input int target, input bit paced);
        int start;
        int pick;
        pace_traffic = paced;
        start        = chars_used;
        while (chars_used - start < target)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                send_random_sentence();
            end
            else if (pick == 7)
            begin
                send_broken_sentence();
            end
            else
            begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin : stimulus
        rst_n         = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_idle_bytes();
        test_known_kinds();
        test_unknown_type();
        test_random_traffic(250, 1'b0);
        test_random_traffic(900, 1'b1);
        rx_if.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial
    begin : result_ready
        int stall;
        res_if.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            stall = pace_traffic ? $urandom_range(0, 4) : 0;
            if (stall > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!(res_if.valid === 1'b1 && res_if.ready === 1'b1));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no sentence pending: kind %0d verdict %0d",
                       res_if.sentence_kind, res_if.verdict);
                error_count++;
            end
            else
            begin
                due = pending_results.pop_front();
                compare_field("sentence_kind", 8'(due.sentence_kind),
                              8'(res_if.sentence_kind));
                compare_field("verdict", 8'(due.verdict), 8'(res_if.verdict));
                compare_field("computed_sum", due.computed_sum, res_if.computed_sum);
                compare_field("received_sum", due.received_sum, res_if.received_sum);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((rx_if.valid === 1'b1 && rx_if.ready === 1'b1) ||
            (res_if.valid === 1'b1 && res_if.ready === 1'b1))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

@@ nmea_sentence_checker_top.f @@
rtl/nsc_pkg.sv
rtl/nsc_byte_if.sv
rtl/nsc_result_if.sv
rtl/nsc_in_stage.sv
rtl/nsc_parser.sv
rtl/nsc_out_stage.sv
rtl/nmea_sentence_checker_top.sv
sim/nmea_sentence_checker_top_tb.sv
